@@ design/lr_pkg.sv @@
// Shared types, widths and codes of the line rasterizer.
package lr_pkg;

   // Canvas side is 2**COORD_BITS pixels; legal range 3 to 6.
   localparam int COORD_BITS = 6;
   // Fixed widths of the channel fields.
   localparam int FIELD_BITS = 6;
   localparam int COLOR_BITS = 8;
   // Span plus one needs one more bit than a coordinate.
   localparam int SPAN_BITS  = COORD_BITS + 1;
   // Error plus increment stays below twice the threshold.
   localparam int ERR_BITS   = COORD_BITS + 2;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [FIELD_BITS-1:0] field_type;
   typedef logic [COLOR_BITS-1:0] color_type;
   typedef logic [SPAN_BITS-1:0]  span_type;
   typedef logic [ERR_BITS-1:0]   err_type;

   // Minor axis step, two's complement.
   typedef enum logic [1:0] {
      DIR_NONE = 2'd0,
      DIR_UP   = 2'd1,
      DIR_DOWN = 2'd3
   } dir_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_RUN
   } state_type;

   typedef struct packed {
      err_type   err;
      span_type  inc;
      span_type  thr;
      coord_type minor;
      dir_type   dir;
   } step_in_type;

   typedef struct packed {
      err_type   err;
      coord_type minor;
   } step_out_type;

endpackage

@@ design/lr_intf.sv @@
// Handshake channels of the line rasterizer: line command and pixel result.
interface lr_req_if;
   import lr_pkg::*;

   logic      valid;
   logic      ready;
   field_type start_x;
   field_type start_y;
   field_type end_x;
   field_type end_y;
   color_type color;

   modport source (output valid, start_x, start_y, end_x, end_y, color, input ready);
   modport sink   (input valid, start_x, start_y, end_x, end_y, color, output ready);
endinterface

interface lr_rsp_if;
   import lr_pkg::*;

   logic      valid;
   logic      ready;
   field_type pixel_x;
   field_type pixel_y;
   color_type pixel_color;
   logic      last_pixel;

   modport source (output valid, pixel_x, pixel_y, pixel_color, last_pixel, input ready);
   modport sink   (input valid, pixel_x, pixel_y, pixel_color, last_pixel, output ready);
endinterface

@@ design/lr_step.sv @@
// Error accumulate, threshold compare and minor-axis step of one pixel.
module lr_step (
   input  lr_pkg::step_in_type  step_in,
   output lr_pkg::step_out_type step_out
);
   import lr_pkg::*;

   err_type sum;
   logic    over;

   assign sum  = step_in.err + ERR_BITS'(step_in.inc);
   assign over = (sum >= ERR_BITS'(step_in.thr));

   always_comb begin
      step_out.err   = over ? (sum - ERR_BITS'(step_in.thr)) : sum;
      step_out.minor = step_in.minor;
      if (over) begin
         unique case (step_in.dir)
            DIR_UP:   step_out.minor = step_in.minor + 1'b1;
            DIR_DOWN: step_out.minor = step_in.minor - 1'b1;
            default:  step_out.minor = step_in.minor;
         endcase
      end
   end

endmodule

@@ design/line_rasterizer_top.sv @@
// Top level of the line rasterizer: command intake, setup, pixel sequencer.
//
// Takes one line command (two endpoints and a colour) per transfer on
// req_chan and returns the pixels of the line on rsp_chan, one transfer per
// pixel, walking the major axis upwards, with last_pixel set on the final
// one. Only the low COORD_BITS bits of each coordinate are used; when both
// spans are equal x is the major axis, and a single point gives one pixel.
// Sequence: a line of n pixels (n = major span + 1, at most 2**COORD_BITS)
// is handled in order: the command is taken into the raw command
// registers, a setup state works out spans, direction and the initial
// error, then the run state gives one pixel per cycle from the shared
// error/step unit, which handles exactly one pixel per cycle, as long as
// the output register has room; a stall on rsp_chan holds the walk.
// req_chan.ready is low from the command transfer until the final pixel
// has entered the output register, which lets the next command be taken
// while the final pixel of the previous line still waits for its transfer.
module line_rasterizer_top (
   input logic      clock,
   input logic      reset,
   lr_req_if.sink   req_chan,
   lr_rsp_if.source rsp_chan
);
   import lr_pkg::*;

   // Sequencer state.
   state_type state_ff, state_in;

   // Raw command, held from transfer to setup.
   coord_type x0_ff, x0_in;
   coord_type y0_ff, y0_in;
   coord_type x1_ff, x1_in;
   coord_type y1_ff, y1_in;
   color_type color_ff, color_in;

   // Walk state.
   coord_type major_ff, major_in;
   coord_type minor_ff, minor_in;
   coord_type end_ff, end_in;
   err_type   err_ff, err_in;
   span_type  inc_ff, inc_in;
   span_type  thr_ff, thr_in;
   dir_type   dir_ff, dir_in;
   logic      steep_ff, steep_in;

   // Output register.
   logic      rsp_valid_ff, rsp_valid_in;
   field_type px_ff, px_in;
   field_type py_ff, py_in;
   color_type pc_ff, pc_in;
   logic      last_ff, last_in;

   // Setup terms.
   coord_type    dx, dy, dmaj, dmin;
   coord_type    ma0, ma1, mi0, mi1;
   logic         steep;
   span_type     setup_inc;
   dir_type      setup_dir;

   // Shared unit.
   step_in_type  step_in;
   step_out_type step_out;

   logic         at_end;
   logic         slot_free;

   assign at_end    = (major_ff == end_ff);
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;

   // Spans, major axis choice and swap so the major coordinate rises.
   always_comb begin
      dx    = (x0_ff >= x1_ff) ? (x0_ff - x1_ff) : (x1_ff - x0_ff);
      dy    = (y0_ff >= y1_ff) ? (y0_ff - y1_ff) : (y1_ff - y0_ff);
      steep = (dy > dx);
      if (steep) begin
         ma0  = y0_ff;
         ma1  = y1_ff;
         mi0  = x0_ff;
         mi1  = x1_ff;
         dmaj = dy;
         dmin = dx;
      end else begin
         ma0  = x0_ff;
         ma1  = x1_ff;
         mi0  = y0_ff;
         mi1  = y1_ff;
         dmaj = dx;
         dmin = dy;
      end
      if (ma0 > ma1) begin
         ma0 = ma1;
         ma1 = steep ? ((y0_ff > y1_ff) ? y0_ff : y1_ff)
                     : ((x0_ff > x1_ff) ? x0_ff : x1_ff);
         mi0 = mi1;
         mi1 = steep ? ((y0_ff > y1_ff) ? x0_ff : x1_ff)
                     : ((x0_ff > x1_ff) ? y0_ff : y1_ff);
      end
      priority if (mi1 > mi0) begin
         setup_dir = DIR_UP;
      end else if (mi1 < mi0) begin
         setup_dir = DIR_DOWN;
      end else begin
         setup_dir = DIR_NONE;
      end
      setup_inc = span_type'(dmin) + 1'b1;
   end

   always_comb begin
      step_in.err   = err_ff;
      step_in.inc   = inc_ff;
      step_in.thr   = thr_ff;
      step_in.minor = minor_ff;
      step_in.dir   = dir_ff;
   end

   lr_step u_step (
      .step_in  (step_in),
      .step_out (step_out)
   );

   // Next state and register loads.
   always_comb begin
      state_in     = state_ff;
      x0_in        = x0_ff;
      y0_in        = y0_ff;
      x1_in        = x1_ff;
      y1_in        = y1_ff;
      color_in     = color_ff;
      major_in     = major_ff;
      minor_in     = minor_ff;
      end_in       = end_ff;
      err_in       = err_ff;
      inc_in       = inc_ff;
      thr_in       = thr_ff;
      dir_in       = dir_ff;
      steep_in     = steep_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      pc_in        = pc_ff;
      last_in      = last_ff;
      // Drop the held pixel once its transfer completes.
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               x0_in    = req_chan.start_x[COORD_BITS-1:0];
               y0_in    = req_chan.start_y[COORD_BITS-1:0];
               x1_in    = req_chan.end_x[COORD_BITS-1:0];
               y1_in    = req_chan.end_y[COORD_BITS-1:0];
               color_in = req_chan.color;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            steep_in = steep;
            major_in = ma0;
            minor_in = mi0;
            end_in   = ma1;
            dir_in   = setup_dir;
            inc_in   = setup_inc;
            thr_in   = span_type'(dmaj) + 1'b1;
            err_in   = ERR_BITS'(setup_inc >> 1);
            state_in = ST_RUN;
         end
         ST_RUN: begin
            // Advance one pixel whenever the output register has room.
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               px_in        = field_type'(steep_ff ? minor_ff : major_ff);
               py_in        = field_type'(steep_ff ? major_ff : minor_ff);
               pc_in        = color_ff;
               last_in      = at_end;
               err_in       = step_out.err;
               minor_in     = step_out.minor;
               if (at_end) begin
                  state_in = ST_IDLE;
               end else begin
                  major_in = major_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x0_ff    <= x0_in;
      y0_ff    <= y0_in;
      x1_ff    <= x1_in;
      y1_ff    <= y1_in;
      color_ff <= color_in;
      major_ff <= major_in;
      minor_ff <= minor_in;
      end_ff   <= end_in;
      err_ff   <= err_in;
      inc_ff   <= inc_in;
      thr_ff   <= thr_in;
      dir_ff   <= dir_in;
      steep_ff <= steep_in;
      px_ff    <= px_in;
      py_ff    <= py_in;
      pc_ff    <= pc_in;
      last_ff  <= last_in;
   end

   // Ready only between lines.
   assign req_chan.ready = (state_ff == ST_IDLE);

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.pixel_x     = px_ff;
   assign rsp_chan.pixel_y     = py_ff;
   assign rsp_chan.pixel_color = pc_ff;
   assign rsp_chan.last_pixel  = last_ff;

endmodule

@@ design/lr_checker.sv @@
// Port-level checks of the line rasterizer, bound to the top level.
module lr_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input lr_pkg::field_type   rsp_pixel_x,
   input lr_pkg::field_type   rsp_pixel_y,
   input lr_pkg::color_type   rsp_pixel_color,
   input logic                rsp_last_pixel
);
   import lr_pkg::*;

   // A command transfer closes the intake for the following cycle.
   a_busy_after_cmd: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("intake open right after a command transfer");

   // While a non-final pixel waits, the line is still being walked.
   a_no_cmd_mid_line: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_pixel) |-> !req_ready)
      else $error("intake open in the middle of a line");

   // A stalled pixel holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_pixel_x) && $stable(rsp_pixel_y)
          && $stable(rsp_pixel_color) && $stable(rsp_last_pixel)))
      else $error("stalled pixel changed");

   // Colour stays fixed within a line.
   a_color_fixed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last_pixel) |=>
         (!rsp_valid || rsp_pixel_color == $past(rsp_pixel_color)))
      else $error("colour changed within a line");

endmodule

bind line_rasterizer_top lr_checker u_lr_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_pixel_x     (rsp_chan.pixel_x),
   .rsp_pixel_y     (rsp_chan.pixel_y),
   .rsp_pixel_color (rsp_chan.pixel_color),
   .rsp_last_pixel  (rsp_chan.last_pixel)
);
